[rtl/core/ips_patch_stream_parser_macros.svh]
// ---------------------------------------------------------------------------
// IPS patch stream parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef IPS_PATCH_STREAM_PARSER_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define IPSP_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define IPSP_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ipsp_pkg.sv]
// ---------------------------------------------------------------------------
// IPS patch stream parser package
// Parser phases, result kinds, register indexes and format constants.
// ---------------------------------------------------------------------------
package ipsp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_ADDR = 3'd2,
    PH_SIZE = 3'd3,
    PH_DATA = 3'd4,
    PH_RLEN = 3'd5,
    PH_RVAL = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_WRITE  = 3'd0,
    K_FILL   = 3'd1,
    K_DONE   = 3'd2,
    K_BADHDR = 3'd3,
    K_TRUNC  = 3'd4,
    K_RANGE  = 3'd5
  } kind_t;

  localparam logic [1:0] CFG_PATCH_LENGTH = 2'd0;
  localparam logic [1:0] CFG_IMAGE_SIZE   = 2'd1;
  localparam logic [1:0] CFG_MEASURE_MODE = 2'd2;

  localparam logic [24:0] MAX_PATCH_BYTES = 25'd1048576;
  localparam logic [24:0] MIN_PATCH_BYTES = 25'd8;
  localparam logic [23:0] EOF_MARK        = 24'h454F46;
  localparam logic [24:0] ADDR_SPACE      = 25'h1000000;
  localparam logic [2:0]  HEADER_LEN      = 3'd5;

  // Bytes of the "PATCH" magic word.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/ips_patch_stream_parser.sv]
// ---------------------------------------------------------------------------
// IPS patch stream parser
// Byte-wide IPS patch decoder producing write, fill and status requests.
// ---------------------------------------------------------------------------
// The parser takes one patch byte per clock cycle while in_tready is high and
// gives at most one result per byte, registered in the cycle after the byte is
// taken. All parsing for a byte is done in a single pass of logic from the
// parser state and the incoming byte into the result register, so the byte
// rate is set by that result register alone: in_tready is high whenever the
// result register is empty or its content is being taken in the same cycle, so
// bytes stream without gaps while the downstream side keeps up. A request with
// in_tuser low starts a new patch and checks patch_length; requests with
// in_tuser high carry patch bytes. Configuration registers are read live and
// take effect at once. There is no clearing pass after reset.
module ips_patch_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] patch_byte
  input  logic        in_tuser,   // [0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [23:0] address, [31:24] value,
                                  // [47:32] run_length, [72:48] extent, rest zero
  output logic [2:0]  out_tuser   // [2:0] kind
);
  import ipsp_pkg::*;

  // Configuration registers.
  logic [20:0] patch_length_r;
  logic [24:0] image_size_r;
  logic        measure_mode_r;

  // Parser state. The byte count is one bit wider than patch_length so that a
  // record running past a shortened length cannot wrap it.
  phase_t      phase_r, phase_nxt;
  logic [21:0] byte_count_r, byte_count_nxt;
  logic [23:0] rec_addr_r, rec_addr_nxt;
  logic [15:0] rec_size_r, rec_size_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [24:0] largest_r, largest_nxt;

  // Result register.
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [23:0] out_addr_r;
  logic [7:0]  out_value_r;
  logic [15:0] out_len_r;
  logic [24:0] out_ext_r;

  // Result of the current byte.
  logic        res_valid;
  kind_t       res_kind;
  logic [23:0] res_addr;
  logic [7:0]  res_value;
  logic [15:0] res_len;
  logic [24:0] res_ext;

  logic        in_acc;

  // The result register frees itself when its content is taken.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_length_r <= '0;
      image_size_r   <= '0;
      measure_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATCH_LENGTH: patch_length_r <= cfg_wdata[20:0];
        CFG_IMAGE_SIZE:   image_size_r   <= cfg_wdata;
        CFG_MEASURE_MODE: measure_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] size_shift;
    logic [24:0] rec_end;
    logic [22:0] need;
    logic        range_fail;
    logic [15:0] data_off;

    b          = in_tdata;
    size_shift = {rec_size_r[7:0], b};
    // End of the record whose size or run length completes with this byte.
    rec_end    = {1'b0, rec_addr_r} + {9'b0, size_shift};
    range_fail = !measure_mode_r && ((rec_end > image_size_r) || (rec_end > ADDR_SPACE));
    need       = '0;
    data_off   = rec_size_r - bytes_left_r;

    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    rec_addr_nxt   = rec_addr_r;
    rec_size_nxt   = rec_size_r;
    bytes_left_nxt = bytes_left_r;
    largest_nxt    = largest_r;

    res_valid = 1'b0;
    res_kind  = K_WRITE;
    res_addr  = '0;
    res_value = '0;
    res_len   = '0;
    res_ext   = '0;

    if (!in_tuser) begin
      // Start of a new patch.
      byte_count_nxt = '0;
      rec_addr_nxt   = '0;
      rec_size_nxt   = '0;
      bytes_left_nxt = '0;
      largest_nxt    = '0;
      if (({4'b0, patch_length_r} < MIN_PATCH_BYTES) ||
          ({4'b0, patch_length_r} > MAX_PATCH_BYTES)) begin
        phase_nxt = PH_IDLE;
        res_valid = 1'b1;
        res_kind  = K_BADHDR;
      end else begin
        phase_nxt = PH_HEAD;
      end
    end else begin
      unique case (phase_r)
        PH_HEAD: begin
          if ((byte_count_r > 22'd4) || (b != magic_byte(byte_count_r[2:0]))) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_kind  = K_BADHDR;
          end else begin
            byte_count_nxt = byte_count_r + 22'd1;
            if (byte_count_r[2:0] == HEADER_LEN - 3'd1) begin
              phase_nxt      = PH_ADDR;
              bytes_left_nxt = 16'd3;
              rec_addr_nxt   = '0;
            end
          end
        end
        PH_ADDR: begin
          rec_addr_nxt   = {rec_addr_r[15:0], b};
          byte_count_nxt = byte_count_r + 22'd1;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_nxt == 16'd0) begin
            if ((rec_addr_nxt == EOF_MARK) && (byte_count_nxt == {1'b0, patch_length_r})) begin
              // Final EOF marker: the patch is complete.
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = K_DONE;
              res_ext   = measure_mode_r ? largest_r : image_size_r;
            end else if ({1'b0, byte_count_nxt} + 23'd2 > {2'b0, patch_length_r}) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = K_TRUNC;
            end else begin
              phase_nxt      = PH_SIZE;
              bytes_left_nxt = 16'd2;
              rec_size_nxt   = '0;
            end
          end
        end
        PH_SIZE: begin
          rec_size_nxt   = size_shift;
          byte_count_nxt = byte_count_r + 22'd1;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_nxt == 16'd0) begin
            if (size_shift != 16'd0) begin
              // Literal record: the data and the next address must fit.
              need = {1'b0, byte_count_nxt} + {7'b0, size_shift} + 23'd3;
              if (need > {2'b0, patch_length_r}) begin
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
                res_kind  = K_TRUNC;
              end else begin
                if (measure_mode_r && (rec_end > largest_r)) begin
                  largest_nxt = rec_end;
                end
                if (range_fail) begin
                  phase_nxt = PH_IDLE;
                  res_valid = 1'b1;
                  res_kind  = K_RANGE;
                end else begin
                  phase_nxt      = PH_DATA;
                  bytes_left_nxt = size_shift;
                end
              end
            end else begin
              // Run record: length, value and the next address must fit.
              if ({1'b0, byte_count_nxt} + 23'd6 > {2'b0, patch_length_r}) begin
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
                res_kind  = K_TRUNC;
              end else begin
                phase_nxt      = PH_RLEN;
                bytes_left_nxt = 16'd2;
              end
            end
          end
        end
        PH_DATA: begin
          byte_count_nxt = byte_count_r + 22'd1;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_nxt == 16'd0) begin
            phase_nxt    = PH_ADDR;
            bytes_left_nxt = 16'd3;
            rec_addr_nxt = '0;
          end
          if (!measure_mode_r) begin
            res_valid = 1'b1;
            res_kind  = K_WRITE;
            res_addr  = rec_addr_r + {8'b0, data_off};
            res_value = b;
          end
        end
        PH_RLEN: begin
          rec_size_nxt   = size_shift;
          byte_count_nxt = byte_count_r + 22'd1;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_nxt == 16'd0) begin
            if (measure_mode_r && (rec_end > largest_r)) begin
              largest_nxt = rec_end;
            end
            if (range_fail) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res_kind  = K_RANGE;
            end else begin
              phase_nxt = PH_RVAL;
            end
          end
        end
        PH_RVAL: begin
          byte_count_nxt = byte_count_r + 22'd1;
          phase_nxt      = PH_ADDR;
          bytes_left_nxt = 16'd3;
          rec_addr_nxt   = '0;
          if (!measure_mode_r) begin
            res_valid = 1'b1;
            res_kind  = K_FILL;
            res_addr  = rec_addr_r;
            res_value = b;
            res_len   = rec_size_r;
          end
        end
        default: ;  // idle: bytes are dropped without a result
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_count_r <= '0;
      rec_addr_r   <= '0;
      rec_size_r   <= '0;
      bytes_left_r <= '0;
      largest_r    <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      rec_addr_r   <= rec_addr_nxt;
      rec_size_r   <= rec_size_nxt;
      bytes_left_r <= bytes_left_nxt;
      largest_r    <= largest_nxt;
    end
  end

  // The result register loads with each accepted byte; a byte without a
  // result leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind_r  <= res_kind;
      out_addr_r  <= res_addr;
      out_value_r <= res_value;
      out_len_r   <= res_len;
      out_ext_r   <= res_ext;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_ext_r, out_len_r, out_value_r, out_addr_r};

`include "ips_patch_stream_parser_macros.svh"

  // A waiting result must hold the input side.
  `IPSP_ASSERT_NOW(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready,
    "input accepted while result stalled")

  // Bytes arriving while idle never produce a result.
  `IPSP_ASSERT_NEXT(a_idle_byte_silent, in_acc && in_tuser && (phase_r == PH_IDLE),
    !out_tvalid, "result produced for byte while idle")

  // A literal record in progress always has data bytes outstanding.
  `IPSP_ASSERT_NOW(a_data_count_live, phase_r == PH_DATA, bytes_left_r != 16'd0,
    "data phase with no bytes left")

endmodule

[bench/tb.sv]
// ---------------------------------------------------------------------------
// IPS patch stream parser testbench
// Streams directed and random IPS patches through the parser under random
// back-pressure and checks every write, fill and status result against a
// cycle-free model of the parser kept in a small scoreboard class.
// ---------------------------------------------------------------------------
module tb;
  import ipsp_pkg::*;

  // Generous bound on the whole run; the slowest legal run is well below it.
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TARGET_REQUESTS = 1250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [24:0] IMAGE_TOP = 25'd16842751;

  // The magic word that every patch opens with.
  localparam logic [7:0] MAGIC_WORD [0:4] = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};

  typedef struct {
    kind_t       kind;
    logic [23:0] address;
    logic [7:0]  value;
    logic [15:0] run_length;
    logic [24:0] extent;
  } parser_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [24:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] patch_byte
  logic        in_tuser;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // [23:0] address, [31:24] value, [47:32] run_length,
                           // [72:48] extent, rest zero
  logic [2:0]  out_tuser;  // [2:0] kind

  ips_patch_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // -------------------------------------------------------------------------
  // Scoreboard. It mirrors the parser state and the three registers, works out
  // the result that each accepted request causes and keeps those results in
  // order until the result channel delivers them.
  // -------------------------------------------------------------------------
  class patch_scoreboard;
    logic [20:0] patch_len;
    logic [24:0] image_sz;
    logic        measure;
    phase_t      phase;
    logic [20:0] byte_cnt;
    logic [23:0] rec_addr;
    logic [15:0] rec_size;
    logic [15:0] left;
    logic [24:0] widest;
    parser_result_t due_results[$];
    int errors;
    int kind_seen[6];

    function new();
      patch_len = '0;
      image_sz  = '0;
      measure   = 1'b0;
      phase     = PH_IDLE;
      byte_cnt  = '0;
      rec_addr  = '0;
      rec_size  = '0;
      left      = '0;
      widest    = '0;
      errors    = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [24:0] v);
      case (idx)
        CFG_PATCH_LENGTH: patch_len = v[20:0];
        CFG_IMAGE_SIZE:   image_sz  = v;
        CFG_MEASURE_MODE: measure   = v[0];
        default: ;
      endcase
    endfunction

    function void add_result(kind_t k, logic [23:0] a, logic [7:0] v, logic [15:0] n,
                             logic [24:0] x);
      parser_result_t r;
      r.kind       = k;
      r.address    = a;
      r.value      = v;
      r.run_length = n;
      r.extent     = x;
      due_results.push_back(r);
    endfunction

    // An error result always drops the parser back to idle.
    function void abandon(kind_t k);
      phase = PH_IDLE;
      add_result(k, '0, '0, '0, '0);
    endfunction

    function void open_record();
      phase    = PH_ADDR;
      left     = 16'd3;
      rec_addr = '0;
    endfunction

    // In measure mode this only tracks the largest end address seen.
    function bit out_of_range();
      logic [24:0] reach;
      reach = {1'b0, rec_addr} + {9'b0, rec_size};
      if (measure) begin
        if (reach > widest) widest = reach;
        return 1'b0;
      end
      return reach > image_sz || reach > ADDR_SPACE;
    endfunction

    // Returns 0 when the parser ignores the request (a byte while idle).
    function bit take_request(bit cmd, logic [7:0] b);
      logic [23:0] a;
      logic [15:0] n;
      if (!cmd) begin
        byte_cnt = '0;
        rec_addr = '0;
        rec_size = '0;
        left     = '0;
        widest   = '0;
        if (patch_len < MIN_PATCH_BYTES || patch_len > MAX_PATCH_BYTES) abandon(K_BADHDR);
        else phase = PH_HEAD;
        return 1'b1;
      end
      if (phase == PH_IDLE) return 1'b0;
      case (phase)
        PH_HEAD: begin
          if (byte_cnt > 4 || b != MAGIC_WORD[byte_cnt]) begin
            abandon(K_BADHDR);
          end else begin
            byte_cnt++;
            if (byte_cnt == HEADER_LEN) open_record();
          end
        end
        PH_ADDR: begin
          rec_addr = {rec_addr[15:0], b};
          byte_cnt++;
          left--;
          if (left == 0) begin
            if (rec_addr == EOF_MARK && byte_cnt == patch_len) begin
              phase = PH_IDLE;
              add_result(K_DONE, '0, '0, '0, measure ? widest : image_sz);
            end else if (byte_cnt + 2 > patch_len) begin
              abandon(K_TRUNC);
            end else begin
              phase    = PH_SIZE;
              left     = 16'd2;
              rec_size = '0;
            end
          end
        end
        PH_SIZE: begin
          rec_size = {rec_size[7:0], b};
          byte_cnt++;
          left--;
          if (left == 0) begin
            if (rec_size != 0) begin
              // A literal record must leave room for at least an address.
              if (byte_cnt + rec_size + 3 > patch_len) abandon(K_TRUNC);
              else if (out_of_range()) abandon(K_RANGE);
              else begin
                phase = PH_DATA;
                left  = rec_size;
              end
            end else if (byte_cnt + 6 > patch_len) begin
              abandon(K_TRUNC);
            end else begin
              phase = PH_RLEN;
              left  = 16'd2;
            end
          end
        end
        PH_DATA: begin
          a = rec_addr + (rec_size - left);
          byte_cnt++;
          left--;
          if (left == 0) open_record();
          if (!measure) add_result(K_WRITE, a, b, '0, '0);
        end
        PH_RLEN: begin
          rec_size = {rec_size[7:0], b};
          byte_cnt++;
          left--;
          if (left == 0) begin
            if (out_of_range()) abandon(K_RANGE);
            else phase = PH_RVAL;
          end
        end
        PH_RVAL: begin
          a = rec_addr;
          n = rec_size;
          byte_cnt++;
          open_record();
          if (!measure) add_result(K_FILL, a, b, n, '0);
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [2:0] kind, logic [79:0] data);
      parser_result_t e;
      if (due_results.size() == 0) begin
        $error("result of kind %0d arrived with none outstanding", kind);
        errors++;
        return;
      end
      e = due_results.pop_front();
      kind_seen[e.kind]++;
      compare("kind", e.kind, kind);
      compare("address", e.address, data[23:0]);
      compare("value", e.value, data[31:24]);
      compare("run_length", e.run_length, data[47:32]);
      compare("extent", e.extent, data[72:48]);
    endfunction
  endclass

  patch_scoreboard sb;

  // Shared between the request side and the result side.
  bit          calm;         // no idling on either side for this patch
  int unsigned holds_asked;  // long receiver hold-offs requested so far
  int unsigned holds_done;
  bit          bulky;        // long literal records, used under a hold-off
  int unsigned cycles;
  int unsigned requests;
  int unsigned parsed;
  int unsigned patches;
  int unsigned measured;
  logic [7:0]  patch_bytes[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $error("run did not finish within %0d cycles", LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result side. Every result taken is checked at once. The ready line then
  // gets one decision per cycle: a requested long hold-off first, then any
  // running random stall, otherwise ready with a chance of a new stall.
  // -------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.match_result(out_tuser, out_tdata);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Request side.
  // -------------------------------------------------------------------------

  // Random gap after a request; most are short, a few are long, and calm
  // patches have none. Valid stays high straight into the next request when
  // there is no gap.
  task automatic pause();
    int unsigned r;
    int unsigned n;
    if (calm) return;
    r = $urandom_range(0, 99);
    n = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one request and waits for the handshake edge.
  task automatic push_request(input bit cmd, input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    requests++;
    if (sb.take_request(cmd, b)) parsed++;
    pause();
  endtask

  // Waits until every expected result has been taken, then lets the parser's
  // result register drain, so that registers change only while idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle, with the write enable held high.
  task automatic configure(input int unsigned len_cfg, input logic [24:0] img,
                           input bit measure_on);
    logic [1:0]  regs [0:2];
    logic [24:0] vals [0:2];
    regs = '{CFG_PATCH_LENGTH, CFG_IMAGE_SIZE, CFG_MEASURE_MODE};
    vals = '{25'(len_cfg), img, {24'b0, measure_on}};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // One literal or run record, placed so that it mostly fits the image; a few
  // land anywhere, and a few use the EOF marker as an ordinary address.
  function automatic void add_record(input bit measure_on, input logic [24:0] img);
    bit          run;
    int unsigned sz;
    int unsigned cap;
    int unsigned r;
    logic [23:0] addr;
    logic [15:0] rlen;
    run = ($urandom_range(0, 99) < 35) && !bulky;
    if (run) begin
      r = $urandom_range(0, 9);
      rlen = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : (r < 6) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 64));
      sz = rlen;
    end else if (bulky) begin
      sz = $urandom_range(30, 40);
    end else begin
      sz = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    end
    cap = (measure_on || img > ADDR_SPACE) ? ADDR_SPACE : img;
    r = $urandom_range(0, 99);
    if (r < 4) addr = EOF_MARK;
    else if (r < 9 || cap < sz) addr = 24'($urandom);
    else addr = 24'($urandom_range(0, cap - sz));
    patch_bytes.push_back(addr[23:16]);
    patch_bytes.push_back(addr[15:8]);
    patch_bytes.push_back(addr[7:0]);
    if (run) begin
      patch_bytes.push_back(8'h00);
      patch_bytes.push_back(8'h00);
      patch_bytes.push_back(rlen[15:8]);
      patch_bytes.push_back(rlen[7:0]);
      patch_bytes.push_back(8'($urandom));
    end else begin
      patch_bytes.push_back(8'(sz >> 8));
      patch_bytes.push_back(8'(sz));
      repeat (sz) patch_bytes.push_back(8'($urandom));
    end
  endfunction

  // Magic word, a number of records, then the EOF marker.
  function automatic void build_patch(input bit measure_on, input logic [24:0] img,
                                      input int unsigned n_records);
    patch_bytes.delete();
    foreach (MAGIC_WORD[i]) patch_bytes.push_back(MAGIC_WORD[i]);
    repeat (n_records) add_record(measure_on, img);
    patch_bytes.push_back(EOF_MARK[23:16]);
    patch_bytes.push_back(EOF_MARK[15:8]);
    patch_bytes.push_back(EOF_MARK[7:0]);
  endfunction

  // Sets the registers, starts a patch and sends the first count bytes of the
  // built patch; past its end, random bytes follow.
  task automatic run_patch(input int unsigned len_cfg, input bit measure_on,
                           input logic [24:0] img, input int unsigned count);
    settle();
    configure(len_cfg, img, measure_on);
    patches++;
    if (measure_on) measured++;
    push_request(1'b0, 8'($urandom));
    for (int unsigned i = 0; i < count; i++)
      push_request(1'b1, (i < patch_bytes.size()) ? patch_bytes[i] : 8'($urandom));
  endtask

  initial begin
    bit          measure_on;
    logic [24:0] img;
    int unsigned total;
    int unsigned pick;
    int unsigned idx;
    int unsigned round;
    int unsigned len_cfg;

    sb          = new();
    calm        = 1'b0;
    bulky       = 1'b0;
    holds_asked = 0;
    holds_done  = 0;
    requests    = 0;
    parsed      = 0;
    patches     = 0;
    measured    = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PATCH_LENGTH;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A length below the minimum is refused at the start, and
    // a byte that then arrives while idle is dropped without a result.
    patch_bytes.delete();
    run_patch(7, 1'b0, 25'd0, 0);
    push_request(1'b1, 8'hFF);
    // A length above the largest patch allowed is refused as well.
    run_patch(32'(MAX_PATCH_BYTES) + 1, 1'b0, IMAGE_TOP, 0);
    // The shortest legal patch: magic word then EOF, in both modes.
    build_patch(1'b0, 25'd0, 0);
    run_patch(8, 1'b0, 25'd0, 8);
    run_patch(8, 1'b1, IMAGE_TOP, 8);
    // A wrong byte inside the magic word.
    patch_bytes[2] = 8'h58;
    run_patch(8, 1'b0, IMAGE_TOP, 3);

    // Random part: mostly well-formed patches with random records, the rest
    // wrong lengths, damaged bytes, cut-off streams, trailing bytes and noise.
    round = 0;
    while (requests < TARGET_REQUESTS) begin
      round++;
      measure_on = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       img = 25'd0;
        1:       img = IMAGE_TOP;
        2:       img = ADDR_SPACE;
        3:       img = 25'($urandom_range(0, 4096));
        default: img = 25'($urandom_range(1 << 20, IMAGE_TOP));
      endcase
      calm  = ($urandom_range(0, 4) == 0);
      bulky = (round == 12 || round == 60);
      if (bulky) begin
        // Long literal records while the receiver holds off, so that the
        // result register fills and the input side has to stall. The earlier
        // results are drained first so that the hold-off meets fresh requests.
        measure_on = 1'b0;
        img = IMAGE_TOP;
        settle();
        holds_asked++;
      end
      build_patch(measure_on, img, bulky ? 4 : $urandom_range(0, 4));
      total = patch_bytes.size();
      pick  = bulky ? 0 : $urandom_range(0, 99);
      if (pick < 65) begin
        run_patch(total, measure_on, img, total);
      end else if (pick < 72) begin
        run_patch(total - $urandom_range(1, 8), measure_on, img, total);
      end else if (pick < 77) begin
        // The stream ends early against the configured length; the patch
        // ends in a truncation result or stays open until the next start.
        len_cfg = ($urandom_range(0, 3) == 0) ? 32'(MAX_PATCH_BYTES)
                                              : total + $urandom_range(1, 5);
        run_patch(len_cfg, measure_on, img, total);
      end else if (pick < 84) begin
        idx = $urandom_range(0, total - 1);
        patch_bytes[idx] = patch_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
        run_patch(total, measure_on, img, total);
      end else if (pick < 90) begin
        // Cut short: the next start arrives in the middle of this patch.
        run_patch(total, measure_on, img, $urandom_range(0, total - 1));
      end else if (pick < 95) begin
        run_patch(total, measure_on, img, total + $urandom_range(1, 4));
      end else begin
        case ($urandom_range(0, 5))
          0:       len_cfg = 0;
          1:       len_cfg = 7;
          2:       len_cfg = 8;
          3:       len_cfg = 32'(MAX_PATCH_BYTES);
          4:       len_cfg = $urandom_range(0, 2097151);
          default: len_cfg = $urandom_range(0, 64);
        endcase
        patch_bytes.delete();
        run_patch(len_cfg, measure_on, img, $urandom_range(1, 20));
      end
    end

    // Drain: everything outstanding must arrive, then the latency runs out.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d patches (%0d in measure mode): %0d requests, %0d of them parsed.",
             patches, measured, requests, parsed);
    $display("Checked %0d writes, %0d fills, %0d done, %0d bad header,",
             sb.kind_seen[K_WRITE], sb.kind_seen[K_FILL], sb.kind_seen[K_DONE],
             sb.kind_seen[K_BADHDR]);
    $display("%0d truncated and %0d out of range.",
             sb.kind_seen[K_TRUNC], sb.kind_seen[K_RANGE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
